// File: design/frr_pkg.sv
// shared types and constants for the fisheye to rectilinear remap core
// no dependencies; every other design file refers to it by scoped names
package frr_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 10;
	localparam int FOCAL_W    = 24;
	localparam int PIX_W      = 48;
	localparam int BANK_AW    = ROW_W + COL_W - 2;
	localparam int BANK_DEPTH = MAX_WIDTH * MAX_HEIGHT / 4;
	localparam int CORDIC_STEPS = 24;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FOCAL  = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 10'd512;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 10'd512;
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 24'd131072;

	// atan(2^-i) in q.24 radians
	localparam logic [24:0] ATAN_Q24 [0:CORDIC_STEPS-1] = '{
		25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214, 25'd524117,
		25'd262123, 25'd131069, 25'd65536, 25'd32768, 25'd16384, 25'd8192,
		25'd4096, 25'd2048, 25'd1024, 25'd512, 25'd256, 25'd128,
		25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2
	};

	// what travels with every item down the pipeline
	typedef struct packed {
		logic        vld;
		logic        qry;
		logic        oob;
		logic [21:0] x;
		logic [21:0] y;
		logic [17:0] waddr;
		logic [47:0] wdata;
	} frr_tag_t;

endpackage

// File: design/frr_radius.sv
// radius stage: squares of the centre offsets and a bit-per-stage square root
// depends on frr_pkg
module frr_radius (
	input  logic             clk,
	input  logic             arst_n,
	input  frr_pkg::frr_tag_t tag_in,
	output frr_pkg::frr_tag_t tag_out,
	output logic [20:0]      root_out
);

	logic signed [21:0] xs, ys;
	logic [20:0] ax, ay;
	frr_pkg::frr_tag_t tag_s1, tag_s2;
	logic [41:0] xx_s1, yy_s1, sum_s2;

	frr_pkg::frr_tag_t tag_s [0:21];
	logic [43:0] rem_s [0:21];
	logic [20:0] root_s [0:21];

	always_comb begin
		xs = $signed(tag_in.x);
		ys = $signed(tag_in.y);
		ax = xs[21] ? 21'(-xs) : xs[20:0];
		ay = ys[21] ? 21'(-ys) : ys[20:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			xx_s1 <= '0;
			yy_s1 <= '0;
			sum_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			xx_s1 <= 42'(ax) * 42'(ax);
			yy_s1 <= 42'(ay) * 42'(ay);
			tag_s2 <= tag_s1;
			sum_s2 <= xx_s1 + yy_s1;
		end
	end

	assign tag_s[0] = tag_s2;
	assign rem_s[0] = {2'b00, sum_s2};
	assign root_s[0] = '0;

	// one root bit per stage, most significant first
	for (genvar k = 1; k <= 21; k++) begin : g_root
		localparam int BIT = 21 - k;
		logic [43:0] trial;
		logic take;

		always_comb begin
			trial = ({23'd0, root_s[k-1]} << (BIT + 1)) + (44'd1 << (2 * BIT));
			take = rem_s[k-1] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
				rem_s[k] <= '0;
				root_s[k] <= '0;
			end else begin
				tag_s[k] <= tag_s[k-1];
				rem_s[k] <= take ? rem_s[k-1] - trial : rem_s[k-1];
				root_s[k] <= take ? (root_s[k-1] | (21'd1 << BIT)) : root_s[k-1];
			end
		end
	end

	assign tag_out = tag_s[21];
	assign root_out = root_s[21];

endmodule

// File: design/frr_cordic.sv
// angle stage: cordic vectoring for atan(r / f), then source radius f * theta
// depends on frr_pkg
module frr_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  frr_pkg::frr_tag_t tag_in,
	input  logic [20:0]       root_in,
	input  logic [23:0]       focal,
	output frr_pkg::frr_tag_t tag_out,
	output logic [20:0]       root_out,
	output logic [29:0]       rin_out
);

	localparam int N = frr_pkg::CORDIC_STEPS;

	frr_pkg::frr_tag_t tag_s [0:N];
	logic [20:0] rq_s [0:N];
	logic signed [31:0] vx_s [0:N];
	logic signed [31:0] vy_s [0:N];
	logic signed [26:0] z_s [0:N];

	frr_pkg::frr_tag_t tag_c1, tag_c2, tag_c3;
	logic [20:0] rq_c1, rq_c2, rq_c3;
	logic [24:0] theta_c1;
	logic [36:0] plo_c2;
	logic [35:0] phi_c2;
	logic [29:0] rin_c3;
	logic [49:0] prod_sum;

	assign tag_s[0] = tag_in;
	assign rq_s[0] = root_in;
	assign vx_s[0] = $signed({4'b0000, focal, 4'b0000});
	assign vy_s[0] = $signed({11'd0, root_in});
	assign z_s[0] = '0;

	for (genvar k = 1; k <= N; k++) begin : g_step
		localparam int SH = k - 1;
		logic signed [31:0] sx, sy;
		logic signed [26:0] ang;

		always_comb begin
			sx = vx_s[k-1] >>> SH;
			sy = vy_s[k-1] >>> SH;
			ang = $signed({2'b00, frr_pkg::ATAN_Q24[SH]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
				rq_s[k] <= '0;
				vx_s[k] <= '0;
				vy_s[k] <= '0;
				z_s[k] <= '0;
			end else begin
				tag_s[k] <= tag_s[k-1];
				rq_s[k] <= rq_s[k-1];
				if (!vy_s[k-1][31]) begin
					vx_s[k] <= vx_s[k-1] + sy;
					vy_s[k] <= vy_s[k-1] - sx;
					z_s[k] <= z_s[k-1] + ang;
				end else begin
					vx_s[k] <= vx_s[k-1] - sy;
					vy_s[k] <= vy_s[k-1] + sx;
					z_s[k] <= z_s[k-1] - ang;
				end
			end
		end
	end

	assign prod_sum = {13'd0, plo_c2} + ({14'd0, phi_c2} << 13) + 50'd524288;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_c1 <= '0;
			tag_c2 <= '0;
			tag_c3 <= '0;
			rq_c1 <= '0;
			rq_c2 <= '0;
			rq_c3 <= '0;
			theta_c1 <= '0;
			plo_c2 <= '0;
			phi_c2 <= '0;
			rin_c3 <= '0;
		end else begin
			tag_c1 <= tag_s[N];
			rq_c1 <= rq_s[N];
			theta_c1 <= z_s[N][26] ? '0 : z_s[N][24:0];
			tag_c2 <= tag_c1;
			rq_c2 <= rq_c1;
			plo_c2 <= 37'(focal) * 37'(theta_c1[12:0]);
			phi_c2 <= 36'(focal) * 36'(theta_c1[24:13]);
			tag_c3 <= tag_c2;
			rq_c3 <= rq_c2;
			rin_c3 <= prod_sum[49:20];
		end
	end

	assign tag_out = tag_c3;
	assign root_out = rq_c3;
	assign rin_out = rin_c3;

endmodule

// File: design/frr_divide.sv
// shift stage: |offset| * rin / r rounded, two restoring dividers side by side
// depends on frr_pkg
module frr_divide (
	input  logic              clk,
	input  logic              arst_n,
	input  frr_pkg::frr_tag_t tag_in,
	input  logic [20:0]       root_in,
	input  logic [29:0]       rin_in,
	output frr_pkg::frr_tag_t tag_out,
	output logic [20:0]       root_out,
	output logic [31:0]       qx_out,
	output logic [31:0]       qy_out
);

	localparam int QB = 32;

	logic signed [21:0] xs, ys;
	logic [20:0] ax, ay;
	frr_pkg::frr_tag_t tag_m1, tag_m2;
	logic [20:0] rq_m1, rq_m2;
	logic [35:0] xlo_m1, xhi_m1, ylo_m1, yhi_m1;
	logic [51:0] nx_m2, ny_m2;

	frr_pkg::frr_tag_t tag_s [0:QB];
	logic [20:0] rq_s [0:QB];
	logic [52:0] remx_s [0:QB];
	logic [52:0] remy_s [0:QB];
	logic [31:0] qx_s [0:QB];
	logic [31:0] qy_s [0:QB];

	always_comb begin
		xs = $signed(tag_in.x);
		ys = $signed(tag_in.y);
		ax = xs[21] ? 21'(-xs) : xs[20:0];
		ay = ys[21] ? 21'(-ys) : ys[20:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_m1 <= '0;
			tag_m2 <= '0;
			rq_m1 <= '0;
			rq_m2 <= '0;
			xlo_m1 <= '0;
			xhi_m1 <= '0;
			ylo_m1 <= '0;
			yhi_m1 <= '0;
			nx_m2 <= '0;
			ny_m2 <= '0;
		end else begin
			tag_m1 <= tag_in;
			rq_m1 <= root_in;
			xlo_m1 <= 36'(ax) * 36'(rin_in[14:0]);
			xhi_m1 <= 36'(ax) * 36'(rin_in[29:15]);
			ylo_m1 <= 36'(ay) * 36'(rin_in[14:0]);
			yhi_m1 <= 36'(ay) * 36'(rin_in[29:15]);
			tag_m2 <= tag_m1;
			rq_m2 <= rq_m1;
			nx_m2 <= {16'd0, xlo_m1} + ({16'd0, xhi_m1} << 15) + {31'd0, rq_m1 >> 1};
			ny_m2 <= {16'd0, ylo_m1} + ({16'd0, yhi_m1} << 15) + {31'd0, rq_m1 >> 1};
		end
	end

	assign tag_s[0] = tag_m2;
	assign rq_s[0] = rq_m2;
	assign remx_s[0] = {1'b0, nx_m2};
	assign remy_s[0] = {1'b0, ny_m2};
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int BIT = QB - k;
		logic [52:0] dsh;
		logic takex, takey;

		always_comb begin
			dsh = {32'd0, rq_s[k-1]} << BIT;
			takex = remx_s[k-1] >= dsh;
			takey = remy_s[k-1] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
				rq_s[k] <= '0;
				remx_s[k] <= '0;
				remy_s[k] <= '0;
				qx_s[k] <= '0;
				qy_s[k] <= '0;
			end else begin
				tag_s[k] <= tag_s[k-1];
				rq_s[k] <= rq_s[k-1];
				remx_s[k] <= takex ? remx_s[k-1] - dsh : remx_s[k-1];
				remy_s[k] <= takey ? remy_s[k-1] - dsh : remy_s[k-1];
				qx_s[k] <= takex ? (qx_s[k-1] | (32'd1 << BIT)) : qx_s[k-1];
				qy_s[k] <= takey ? (qy_s[k-1] | (32'd1 << BIT)) : qy_s[k-1];
			end
		end
	end

	assign tag_out = tag_s[QB];
	assign root_out = rq_s[QB];
	assign qx_out = qx_s[QB];
	assign qy_out = qy_s[QB];

endmodule

// File: design/frr_interp.sv
// source position, four-bank frame store and bilinear blend of the neighbours
// depends on frr_pkg
module frr_interp (
	input  logic              clk,
	input  logic              arst_n,
	input  frr_pkg::frr_tag_t tag_in,
	input  logic [20:0]       root_in,
	input  logic [31:0]       qx_in,
	input  logic [31:0]       qy_in,
	input  logic [9:0]        w_use,
	input  logic [9:0]        h_use,
	output logic [15:0]       red_out,
	output logic [15:0]       green_out,
	output logic [15:0]       blue_out,
	output logic              outside,
	output logic              done
);

	logic signed [34:0] cxq, cyq, cin_n, rin_n;
	frr_pkg::frr_tag_t tag_p1;
	logic signed [34:0] cin_p1, rin_p1;

	logic signed [22:0] c0, r0, c0p, r0p;
	logic off_frame;
	logic [8:0] c_lo, c_hi, col_even, col_odd, r_lo, r_hi, row_even, row_odd;
	logic wr_en;
	logic [1:0] wr_bank;
	logic [frr_pkg::BANK_AW-1:0] wr_addr;

	logic [47:0] rd_p2 [0:3];
	logic [11:0] a_p2, b_p2;
	logic rpar_p2, cpar_p2, out_p2, vld_p2;

	logic [12:0] wa, wb_p3;
	logic [47:0] p00, p01, p10, p11;
	logic [28:0] m00_p3 [0:2];
	logic [28:0] m01_p3 [0:2];
	logic [28:0] m10_p3 [0:2];
	logic [28:0] m11_p3 [0:2];
	logic out_p3, vld_p3;

	logic [41:0] nt_p4 [0:2];
	logic [41:0] nb_p4 [0:2];
	logic out_p4, vld_p4;

	logic [15:0] chan_p5 [0:2];
	logic out_p5, vld_p5;

	always_comb begin
		cxq = $signed({14'd0, w_use, 11'd0});
		cyq = $signed({14'd0, h_use, 11'd0});
		if (root_in == '0) begin
			cin_n = cxq;
			rin_n = cyq;
		end else begin
			cin_n = tag_in.x[21] ? cxq - $signed({3'b000, qx_in}) : cxq + $signed({3'b000, qx_in});
			rin_n = tag_in.y[21] ? cyq - $signed({3'b000, qy_in}) : cyq + $signed({3'b000, qy_in});
		end
	end

	always_comb begin
		c0 = cin_p1[34:12];
		r0 = rin_p1[34:12];
		c0p = c0 + 23'sd1;
		r0p = r0 + 23'sd1;
		off_frame = tag_p1.oob || c0[22] || r0[22]
			|| (c0p >= $signed({13'd0, w_use})) || (r0p >= $signed({13'd0, h_use}));
		c_lo = c0[8:0];
		c_hi = c_lo + 9'd1;
		col_even = c_lo[0] ? c_hi : c_lo;
		col_odd = c_lo[0] ? c_lo : c_hi;
		r_lo = r0[8:0];
		r_hi = r_lo + 9'd1;
		row_even = r_lo[0] ? r_hi : r_lo;
		row_odd = r_lo[0] ? r_lo : r_hi;
		wr_en = tag_p1.vld && (tag_p1.qry == frr_pkg::CMD_WRITE);
		wr_bank = {tag_p1.waddr[9], tag_p1.waddr[0]};
		wr_addr = {tag_p1.waddr[17:10], tag_p1.waddr[8:1]};
	end

	// banks by row and column parity so the four neighbours read at once
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);
		logic [47:0] mem [0:frr_pkg::BANK_DEPTH-1];
		logic [frr_pkg::BANK_AW-1:0] rd_addr;

		assign rd_addr = {BID[1] ? row_odd[8:1] : row_even[8:1],
			BID[0] ? col_odd[8:1] : col_even[8:1]};

		always_ff @(posedge clk) begin
			if (wr_en && wr_bank == BID) begin
				mem[wr_addr] <= tag_p1.wdata;
			end
			rd_p2[b] <= mem[rd_addr];
		end
	end

	always_comb begin
		p00 = rd_p2[{rpar_p2, cpar_p2}];
		p01 = rd_p2[{rpar_p2, ~cpar_p2}];
		p10 = rd_p2[{~rpar_p2, cpar_p2}];
		p11 = rd_p2[{~rpar_p2, ~cpar_p2}];
		wa = 13'd4096 - {1'b0, a_p2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_p1 <= '0;
			cin_p1 <= '0;
			rin_p1 <= '0;
			a_p2 <= '0;
			b_p2 <= '0;
			rpar_p2 <= 1'b0;
			cpar_p2 <= 1'b0;
			out_p2 <= 1'b0;
			vld_p2 <= 1'b0;
			wb_p3 <= '0;
			out_p3 <= 1'b0;
			vld_p3 <= 1'b0;
			out_p4 <= 1'b0;
			vld_p4 <= 1'b0;
			out_p5 <= 1'b0;
			vld_p5 <= 1'b0;
		end else begin
			tag_p1 <= tag_in;
			cin_p1 <= cin_n;
			rin_p1 <= rin_n;
			a_p2 <= cin_p1[11:0];
			b_p2 <= rin_p1[11:0];
			rpar_p2 <= r0[0];
			cpar_p2 <= c0[0];
			out_p2 <= off_frame;
			vld_p2 <= tag_p1.vld && (tag_p1.qry == frr_pkg::CMD_QUERY);
			wb_p3 <= {1'b0, b_p2};
			out_p3 <= out_p2;
			vld_p3 <= vld_p2;
			out_p4 <= out_p3;
			vld_p4 <= vld_p3;
			out_p5 <= out_p4;
			vld_p5 <= vld_p4;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		localparam int HI = 47 - 16 * ch;
		logic [28:0] top, bot;
		logic [41:0] acc;

		assign top = m00_p3[ch] + m01_p3[ch];
		assign bot = m10_p3[ch] + m11_p3[ch];
		assign acc = nt_p4[ch] + nb_p4[ch] + 42'd8388608;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				m00_p3[ch] <= '0;
				m01_p3[ch] <= '0;
				m10_p3[ch] <= '0;
				m11_p3[ch] <= '0;
				nt_p4[ch] <= '0;
				nb_p4[ch] <= '0;
				chan_p5[ch] <= '0;
			end else begin
				m00_p3[ch] <= 29'(p00[HI -: 16]) * 29'(wa);
				m01_p3[ch] <= 29'(p01[HI -: 16]) * 29'(a_p2);
				m10_p3[ch] <= 29'(p10[HI -: 16]) * 29'(wa);
				m11_p3[ch] <= 29'(p11[HI -: 16]) * 29'(a_p2);
				nt_p4[ch] <= 42'(top) * 42'(13'd4096 - wb_p3);
				nb_p4[ch] <= 42'(bot) * 42'(wb_p3);
				chan_p5[ch] <= out_p4 ? '0 : acc[39:24];
			end
		end
	end

	assign red_out = chan_p5[0];
	assign green_out = chan_p5[1];
	assign blue_out = chan_p5[2];
	assign outside = out_p5;
	assign done = vld_p5;

endmodule

// File: design/fisheye_to_rectilinear_remap_core.sv
// top level of the fisheye to rectilinear remap core: registers and pipeline
// depends on frr_pkg, frr_radius, frr_cordic, frr_divide, frr_interp
// One item is accepted every cycle (busy stays low). A query's result appears
// with done high once it has passed the 21-stage square root, the 24-stage
// cordic, the 32-stage divider and the blend. Pixel writes travel the same
// pipeline and land in the frame store, so queries always see writes in issue
// order. The frame store is four banks split by row and column parity, reading
// all four neighbours of a query at once. The receiver cannot stall; results
// are never held. The user must write configuration only while the pipeline
// is empty; the block itself does not enforce it.
module fisheye_to_rectilinear_remap_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [8:0]  row,
	input  logic [8:0]  col,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic        outside,
	output logic        done
);

	logic [9:0] width_q, height_q;
	logic [23:0] focal_q;
	logic [9:0] w_use, h_use;
	logic [23:0] f_use;
	frr_pkg::frr_tag_t tag_in;

	frr_pkg::frr_tag_t tag_r, tag_c, tag_d;
	logic [20:0] root_r, root_c, root_d;
	logic [29:0] rin_c;
	logic [31:0] qx_d, qy_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= frr_pkg::WIDTH_RESET;
			height_q <= frr_pkg::HEIGHT_RESET;
			focal_q <= frr_pkg::FOCAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				frr_pkg::REG_WIDTH: width_q <= cfg_data[9:0];
				frr_pkg::REG_HEIGHT: height_q <= cfg_data[9:0];
				frr_pkg::REG_FOCAL: focal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < 10'd2) w_use = 10'd2;
		else if (width_q > 10'(frr_pkg::MAX_WIDTH)) w_use = 10'(frr_pkg::MAX_WIDTH);
		else w_use = width_q;
		if (height_q < 10'd2) h_use = 10'd2;
		else if (height_q > 10'(frr_pkg::MAX_HEIGHT)) h_use = 10'(frr_pkg::MAX_HEIGHT);
		else h_use = height_q;
		f_use = (focal_q == '0) ? 24'd1 : focal_q;

		tag_in.vld = start && !busy;
		tag_in.qry = cmd;
		tag_in.oob = ({1'b0, row} >= h_use) || ({1'b0, col} >= w_use);
		tag_in.x = 22'({1'b0, col, 12'd0}) - 22'({1'b0, w_use, 11'd0});
		tag_in.y = 22'({1'b0, row, 12'd0}) - 22'({1'b0, h_use, 11'd0});
		tag_in.waddr = {row, col};
		tag_in.wdata = {red_in, green_in, blue_in};
	end

	assign busy = 1'b0;

	frr_radius u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_in),
		.tag_out  (tag_r),
		.root_out (root_r)
	);

	frr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_r),
		.root_in  (root_r),
		.focal    (f_use),
		.tag_out  (tag_c),
		.root_out (root_c),
		.rin_out  (rin_c)
	);

	frr_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_c),
		.root_in  (root_c),
		.rin_in   (rin_c),
		.tag_out  (tag_d),
		.root_out (root_d),
		.qx_out   (qx_d),
		.qy_out   (qy_d)
	);

	frr_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_d),
		.root_in   (root_d),
		.qx_in     (qx_d),
		.qy_in     (qy_d),
		.w_use     (w_use),
		.h_use     (h_use),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.outside   (outside),
		.done      (done)
	);

endmodule

// File: verif/frr_checker.sv
`timescale 1ns / 1ps
// checker for the fisheye to rectilinear remap core: predicts each query result
// from its own copy of the frame store and registers; depends on frr_pkg
module frr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [8:0]  row,
	input  logic [8:0]  col,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic [15:0] red_out,
	input  logic [15:0] green_out,
	input  logic [15:0] blue_out,
	input  logic        outside,
	input  logic        done,
	output int          pending,
	output int          errors
);

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        off;
		logic        chk;
	} pixel_result_t;

	logic [47:0] frame_mem [0:frr_pkg::MAX_WIDTH*frr_pkg::MAX_HEIGHT-1];
	bit written [0:frr_pkg::MAX_WIDTH*frr_pkg::MAX_HEIGHT-1];
	logic [frr_pkg::SIZE_W-1:0] width_reg;
	logic [frr_pkg::SIZE_W-1:0] height_reg;
	logic [frr_pkg::FOCAL_W-1:0] focal_reg;
	pixel_result_t expected_pixels [$];

	assign pending = expected_pixels.size();

	function automatic longint scale_offset(longint d, longint unsigned rin,
			longint unsigned r);
		longint unsigned mag;
		longint unsigned q;
		if (r == 0)
			return 0;
		mag = d < 0 ? -d : d;
		q = (mag * rin + r / 2) / r;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic pixel_result_t remap_pixel(logic [8:0] qr, logic [8:0] qc);
		longint w, h, f, cx, cy, x, y, vx, vy, z, sx, sy, cin, rin, c0, r0, base;
		longint unsigned sum, rq, bitv, rinq, a, b, top, bot;
		logic [47:0] p00, p01, p10, p11;
		pixel_result_t res;
		res = '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
		w = width_reg < 2 ? 2 : (width_reg > frr_pkg::MAX_WIDTH ? frr_pkg::MAX_WIDTH :
			width_reg);
		h = height_reg < 2 ? 2 : (height_reg > frr_pkg::MAX_HEIGHT ? frr_pkg::MAX_HEIGHT :
			height_reg);
		if (qr >= h || qc >= w)
			return res;
		f = focal_reg == 0 ? 1 : focal_reg;
		cx = w << 11;
		cy = h << 11;
		x = (longint'(qc) << 12) - cx;
		y = (longint'(qr) << 12) - cy;
		sum = x * x + y * y;
		rq = 0;
		bitv = 64'd1 << 62;
		while (bitv > sum)
			bitv >>= 2;
		while (bitv != 0) begin
			if (sum >= rq + bitv) begin
				sum -= rq + bitv;
				rq = (rq >> 1) + bitv;
			end else begin
				rq >>= 1;
			end
			bitv >>= 2;
		end
		vx = f << 4;
		vy = longint'(rq);
		z = 0;
		for (int i = 0; i < frr_pkg::CORDIC_STEPS; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx += sy; vy -= sx; z += longint'(frr_pkg::ATAN_Q24[i]);
			end else begin
				vx -= sy; vy += sx; z -= longint'(frr_pkg::ATAN_Q24[i]);
			end
		end
		if (z < 0)
			z = 0;
		rinq = (f * z + (64'd1 << 19)) >> 20;
		cin = cx + scale_offset(x, rinq, rq);
		rin = cy + scale_offset(y, rinq, rq);
		c0 = cin >>> 12;
		r0 = rin >>> 12;
		if (c0 < 0 || c0 + 1 >= w || r0 < 0 || r0 + 1 >= h)
			return res;
		a = cin - (c0 << 12);
		b = rin - (r0 << 12);
		base = r0 * frr_pkg::MAX_WIDTH + c0;
		p00 = frame_mem[base];
		p01 = frame_mem[base + 1];
		p10 = frame_mem[base + frr_pkg::MAX_WIDTH];
		p11 = frame_mem[base + frr_pkg::MAX_WIDTH + 1];
		// channels of never-written neighbours carry no expectation
		res.chk = written[base] && written[base + 1] && written[base + frr_pkg::MAX_WIDTH]
			&& written[base + frr_pkg::MAX_WIDTH + 1];
		for (int ch = 0; ch < 3; ch++) begin
			top = p00[ch*16 +: 16] * (4096 - a) + p01[ch*16 +: 16] * a;
			bot = p10[ch*16 +: 16] * (4096 - a) + p11[ch*16 +: 16] * a;
			top = (top * (4096 - b) + bot * b + (64'd1 << 23)) >> 24;
			case (ch)
				0: res.blue = top[15:0];
				1: res.green = top[15:0];
				default: res.red = top[15:0];
			endcase
		end
		res.off = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_px;
		if (!arst_n) begin
			width_reg = frr_pkg::WIDTH_RESET;
			height_reg = frr_pkg::HEIGHT_RESET;
			focal_reg = frr_pkg::FOCAL_RESET;
			errors = 0;
		end else begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$error("result with no query pending");
					errors++;
				end else begin
					exp_px = expected_pixels.pop_front();
					if (exp_px.chk && red_out !== exp_px.red) begin
						$error("red_out expected %h actual %h", exp_px.red, red_out);
						errors++;
					end
					if (exp_px.chk && green_out !== exp_px.green) begin
						$error("green_out expected %h actual %h", exp_px.green, green_out);
						errors++;
					end
					if (exp_px.chk && blue_out !== exp_px.blue) begin
						$error("blue_out expected %h actual %h", exp_px.blue, blue_out);
						errors++;
					end
					if (outside !== exp_px.off) begin
						$error("outside expected %b actual %b", exp_px.off, outside);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					frr_pkg::REG_WIDTH: width_reg = cfg_data[frr_pkg::SIZE_W-1:0];
					frr_pkg::REG_HEIGHT: height_reg = cfg_data[frr_pkg::SIZE_W-1:0];
					frr_pkg::REG_FOCAL: focal_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd == frr_pkg::CMD_WRITE) begin
					frame_mem[{row, col}] = {red_in, green_in, blue_in};
					written[{row, col}] = 1'b1;
				end else begin
					expected_pixels.push_back(remap_pixel(row, col));
				end
			end
		end
	end

endmodule

// File: verif/tb_fisheye_to_rectilinear_remap_core.sv
`timescale 1ns / 1ps
// stimulus and verdict for the fisheye to rectilinear remap core
// depends on frr_pkg, the core and frr_checker
module tb_fisheye_to_rectilinear_remap_core;

	localparam int DRAIN_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 200000;
	localparam int FILL_SIDE = 32;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cmd = frr_pkg::CMD_WRITE;
	logic [8:0] row = '0;
	logic [8:0] col = '0;
	logic [15:0] red_in = '0;
	logic [15:0] green_in = '0;
	logic [15:0] blue_in = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = frr_pkg::REG_WIDTH;
	logic [23:0] cfg_data = '0;
	logic busy, done, outside;
	logic [15:0] red_out, green_out, blue_out;
	int pending, errors;
	int cur_w = frr_pkg::MAX_WIDTH;
	int cur_h = frr_pkg::MAX_HEIGHT;
	longint cycles = 0;

	always #5 clk = ~clk;

	fisheye_to_rectilinear_remap_core u_dut (.*);
	frr_checker u_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send(logic c, logic [8:0] r, logic [8:0] k,
			logic [15:0] rv, logic [15:0] gv, logic [15:0] bv);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c; row <= r; col <= k;
		red_in <= rv; green_in <= gv; blue_in <= bv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause_random();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		n = pick < 65 ? 0 : (pick < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == frr_pkg::REG_WIDTH)
			cur_w = val[9:0] < 2 ? 2 : (val[9:0] > frr_pkg::MAX_WIDTH ? frr_pkg::MAX_WIDTH :
				val[9:0]);
		if (idx == frr_pkg::REG_HEIGHT)
			cur_h = val[9:0] < 2 ? 2 : (val[9:0] > frr_pkg::MAX_HEIGHT ? frr_pkg::MAX_HEIGHT :
				val[9:0]);
	endtask

	task automatic random_items(int count);
		logic [8:0] r, k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 4) begin
				if ($urandom_range(0, 3) == 0) begin
					r = 9'($urandom);
					k = 9'($urandom);
				end else begin
					r = 9'($urandom_range(0, FILL_SIDE - 1));
					k = 9'($urandom_range(0, FILL_SIDE - 1));
				end
				send(frr_pkg::CMD_WRITE, r, k, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					r = 9'($urandom);
					k = 9'($urandom);
				end else begin
					r = 9'($urandom_range(0, cur_h - 1));
					k = 9'($urandom_range(0, cur_w - 1));
				end
				send(frr_pkg::CMD_QUERY, r, k, 16'($urandom), 16'($urandom), 16'($urandom));
			end
			pause_random();
		end
	endtask

	initial begin
		int wv, hv, fv;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// top-left window written so small frames only read written pixels
		for (int i = 0; i < FILL_SIDE * FILL_SIDE; i++)
			send(frr_pkg::CMD_WRITE, 9'(i / FILL_SIDE), 9'(i % FILL_SIDE),
				16'($urandom), 16'($urandom), 16'($urandom));
		send(frr_pkg::CMD_WRITE, 9'd0, 9'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
		send(frr_pkg::CMD_WRITE, 9'd511, 9'd511, 16'h0000, 16'hFFFF, 16'h0000);
		send(frr_pkg::CMD_QUERY, 9'd0, 9'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(frr_pkg::CMD_QUERY, 9'd511, 9'd511, 16'h0000, 16'h0000, 16'h0000);
		send(frr_pkg::CMD_QUERY, 9'd256, 9'd256, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd255, 9'd257, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd0, 9'd511, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd511, 9'd0, 16'h0, 16'h0, 16'h0);
		write_reg(frr_pkg::REG_FOCAL, 24'd256);
		send(frr_pkg::CMD_QUERY, 9'd0, 9'd0, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd300, 9'd100, 16'h0, 16'h0, 16'h0);
		write_reg(frr_pkg::REG_WIDTH, 24'd100);
		write_reg(frr_pkg::REG_HEIGHT, 24'd80);
		send(frr_pkg::CMD_QUERY, 9'd79, 9'd99, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd80, 9'd10, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd10, 9'd100, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd40, 9'd50, 16'h0, 16'h0, 16'h0);
		write_reg(frr_pkg::REG_FOCAL, 24'd0);
		send(frr_pkg::CMD_QUERY, 9'd0, 9'd0, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd41, 9'd51, 16'h0, 16'h0, 16'h0);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send(frr_pkg::CMD_QUERY, 9'd20, 9'd30, 16'h0, 16'h0, 16'h0);
		write_reg(frr_pkg::REG_WIDTH, 24'd0);
		write_reg(frr_pkg::REG_HEIGHT, 24'd1);
		write_reg(frr_pkg::REG_FOCAL, 24'hFFFFFF);
		send(frr_pkg::CMD_QUERY, 9'd0, 9'd0, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd1, 9'd1, 16'h0, 16'h0, 16'h0);
		send(frr_pkg::CMD_QUERY, 9'd2, 9'd0, 16'h0, 16'h0, 16'h0);
		random_items(100);
		write_reg(frr_pkg::REG_WIDTH, 24'h3FF);
		write_reg(frr_pkg::REG_HEIGHT, 24'h3FF);
		write_reg(frr_pkg::REG_FOCAL, 24'd1);
		random_items(60);
		for (int phase = 0; phase < 5; phase++) begin
			if (phase == 0) begin
				wv = 2;
				hv = 2;
			end else if (phase == 1) begin
				wv = $urandom_range(FILL_SIDE + 1, 512);
				hv = $urandom_range(FILL_SIDE + 1, 512);
			end else begin
				wv = $urandom_range(2, FILL_SIDE);
				hv = $urandom_range(2, FILL_SIDE);
			end
			fv = phase == 1 ? 24'hFFFFFF : $urandom_range(256, 600000);
			write_reg(frr_pkg::REG_WIDTH, 24'(wv));
			write_reg(frr_pkg::REG_HEIGHT, 24'(hv));
			write_reg(frr_pkg::REG_FOCAL, 24'(fv));
			random_items(60);
			drain();
			random_items(60);
		end
		write_reg(frr_pkg::REG_WIDTH, 24'd512);
		write_reg(frr_pkg::REG_HEIGHT, 24'd512);
		write_reg(frr_pkg::REG_FOCAL, 24'd131072);
		random_items(100);
		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
